FILE: design/apss_pkg.sv
// Shared types and constants of the autorange power sample scaler.
package apss_pkg;

  localparam int unsigned READING_W   = 10;
  localparam int unsigned THRESH_W    = 10;
  localparam int unsigned NUMER_W     = 22;
  localparam int unsigned DENOM_W     = 24;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned SEQ_W       = 8;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 88;

  // Divider sizing: dividend is diff * numerator plus half the divisor,
  // divisor is denominator times the high gain.
  localparam int unsigned PROD_W     = READING_W + NUMER_W;
  localparam int unsigned DIVIDEND_W = PROD_W + 1;
  localparam int unsigned DIVISOR_W  = DENOM_W + 5;
  localparam int unsigned QUOT_W     = 16;
  localparam int unsigned DIV_STEPS  = QUOT_W + 1;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int unsigned SHIFT_W    = DIVISOR_W + QUOT_W;

  localparam int unsigned HIGH_GAIN          = 20;
  localparam int unsigned VBAT_NUMERATOR     = 1126400;
  localparam int unsigned HISTORY_DEPTH_DEF  = 4;

  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(512);
  localparam logic [NUMER_W-1:0]  NUMER_RESET  = NUMER_W'(3300);
  localparam logic [DENOM_W-1:0]  DENOM_RESET  = DENOM_W'(1024);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RANGE_THRESHOLD   = 2'd0,
    REG_SCALE_NUMERATOR   = 2'd1,
    REG_SCALE_DENOMINATOR = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_POW_GO,
    ST_POW_WAIT,
    ST_BAT_GO,
    ST_BAT_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_res_t;

endpackage

FILE: design/apss_div.sv
// Iterative restoring divider with 16-bit saturating quotient.
module apss_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [apss_pkg::DIVIDEND_W-1:0]      dividend,
  input  logic [apss_pkg::DIVISOR_W-1:0]       divisor,
  output apss_pkg::div_res_t                   res
);

  logic [apss_pkg::DIVIDEND_W-1:0] rem_r, rem_nxt;
  logic [apss_pkg::SHIFT_W-1:0]    dsh_r, dsh_nxt;
  logic [apss_pkg::DIV_STEPS-1:0]  q_r, q_nxt;
  logic [apss_pkg::DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;

  logic [apss_pkg::SHIFT_W-1:0]    rem_ext;
  logic [apss_pkg::SHIFT_W-1:0]    sub;
  logic                            ge;

  // one compare/subtract per cycle against the shifted divisor
  assign rem_ext = apss_pkg::SHIFT_W'(rem_r);
  assign ge      = rem_ext >= dsh_r;
  assign sub     = rem_ext - dsh_r;

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = dividend;
      dsh_nxt  = {divisor, {apss_pkg::QUOT_W{1'b0}}};
      q_nxt    = '0;
      cnt_nxt  = apss_pkg::DIV_CNT_W'(apss_pkg::DIV_STEPS - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[apss_pkg::DIV_STEPS-2:0], ge};
      rem_nxt = ge ? sub[apss_pkg::DIVIDEND_W-1:0] : rem_r;
      dsh_nxt = dsh_r >> 1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
  end

  // top quotient bit set means >= 65536 (also covers a zero divisor)
  assign res.done = done_r;
  assign res.quot = q_r[apss_pkg::DIV_STEPS-1] ? {apss_pkg::QUOT_W{1'b1}}
                                               : q_r[apss_pkg::QUOT_W-1:0];

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider restarted while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("done while still busy");
  a_fell_done: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> done_r) else $error("busy dropped without done");

endmodule

FILE: design/autorange_power_sample_scaler_top.sv
// Top level of the autorange power sample scaler.
//
// Usage:
//   in_*  : one item at a time, taken only in idle, four 10-bit converter readings in in_tdata.
//   out_* : one result item per input item: power history, battery mV and
//           sequence number in out_tdata.
//   cfg_* : register writes (threshold, numerator, denominator), taken on
//           any edge with cfg_we high; write only while the block is idle.
// Timing: an item is taken only in idle, then range select and multiply,
//   a launch step, a 17-step shared divider pass and a collect step for the
//   power, the same for the battery voltage, and an emit step that loads the
//   output register.
//   No new item is accepted until the result has been emitted; the single
//   divider serves both divisions in turn.
// Reset: registers return to defaults, power history and sequence count are
//   cleared, no output is valid.
// Stall: a finished result waits in the output register; a following result
//   holds in the emit step until the previous one is taken, and no new item
//   is accepted meanwhile.
module autorange_power_sample_scaler_top #(
  parameter int unsigned HISTORY_DEPTH = apss_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // coil_unity, coil_high_gain, offset_high_gain, supply_reading (low first)
  input  logic [apss_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // power_newest, power_prev1, power_prev2, power_prev3, battery_mv,
  // sequence_res (low first)
  output logic [apss_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_we,
  input  logic [apss_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [apss_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int unsigned RW = apss_pkg::READING_W;
  localparam int unsigned SW = apss_pkg::SAMPLE_W;

  apss_pkg::state_t state_r, state_nxt;

  // config registers
  logic [apss_pkg::THRESH_W-1:0] thresh_r;
  logic [apss_pkg::NUMER_W-1:0]  numer_r;
  logic [apss_pkg::DENOM_W-1:0]  denom_r;

  // captured readings
  logic [RW-1:0] unity_r, high_r, offs_r, supply_r;

  // prep results
  logic [apss_pkg::PROD_W-1:0]    prod_r;
  logic [apss_pkg::DIVISOR_W-1:0] den_r;
  logic                           neg_r;

  logic [SW-1:0] pow_r, bat_r;
  logic [apss_pkg::SEQ_W-1:0] seq_r;
  logic [SW-1:0] hist_r [HISTORY_DEPTH];

  logic [apss_pkg::OUT_DATA_W-1:0] out_tdata_r;
  logic                            out_tvalid_r;

  logic in_fire, emit;

  // range selection
  logic                           use_high;
  logic [RW-1:0]                  value, offset, diff;
  logic [apss_pkg::DIVISOR_W-1:0] den_base, den_sel;

  // divider hookup
  logic                              div_start;
  logic [apss_pkg::DIVIDEND_W-1:0]   div_dividend;
  logic [apss_pkg::DIVISOR_W-1:0]    div_divisor;
  apss_pkg::div_res_t                div_res;

  logic [SW-1:0] prev [1:3];

  assign in_tready = (state_r == apss_pkg::ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign emit      = (state_r == apss_pkg::ST_EMIT) && (!out_tvalid_r || out_tready);

  // unity reading below threshold switches to the 20x channel
  assign use_high = unity_r < thresh_r;
  assign value    = use_high ? high_r : unity_r;
  assign offset   = use_high ? offs_r : '0;
  assign diff     = value - offset;
  assign den_base = apss_pkg::DIVISOR_W'(denom_r);
  // x20 as x16 + x4
  assign den_sel  = use_high ? ((den_base << 4) + (den_base << 2)) : den_base;

  // rounding: add half the divisor before dividing
  always_comb begin
    div_start    = 1'b0;
    div_dividend = {1'b0, prod_r} + apss_pkg::DIVIDEND_W'(den_r >> 1);
    div_divisor  = den_r;
    unique case (state_r)
      apss_pkg::ST_POW_GO: div_start = 1'b1;
      apss_pkg::ST_BAT_GO: begin
        div_start    = 1'b1;
        div_dividend = apss_pkg::DIVIDEND_W'(apss_pkg::VBAT_NUMERATOR)
                     + apss_pkg::DIVIDEND_W'(supply_r >> 1);
        div_divisor  = apss_pkg::DIVISOR_W'(supply_r);
      end
      default: ;
    endcase
  end

  apss_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .res      (div_res)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      apss_pkg::ST_IDLE:     if (in_fire) state_nxt = apss_pkg::ST_PREP;
      apss_pkg::ST_PREP:     state_nxt = apss_pkg::ST_POW_GO;
      apss_pkg::ST_POW_GO:   state_nxt = apss_pkg::ST_POW_WAIT;
      apss_pkg::ST_POW_WAIT: if (div_res.done) state_nxt = apss_pkg::ST_BAT_GO;
      apss_pkg::ST_BAT_GO:   state_nxt = apss_pkg::ST_BAT_WAIT;
      apss_pkg::ST_BAT_WAIT: if (div_res.done) state_nxt = apss_pkg::ST_EMIT;
      apss_pkg::ST_EMIT:     if (emit) state_nxt = apss_pkg::ST_IDLE;
      default:               state_nxt = apss_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= apss_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // config writes; unknown index ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= apss_pkg::THRESH_RESET;
      numer_r  <= apss_pkg::NUMER_RESET;
      denom_r  <= apss_pkg::DENOM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        apss_pkg::REG_RANGE_THRESHOLD:   thresh_r <= cfg_wdata[apss_pkg::THRESH_W-1:0];
        apss_pkg::REG_SCALE_NUMERATOR:   numer_r  <= cfg_wdata[apss_pkg::NUMER_W-1:0];
        apss_pkg::REG_SCALE_DENOMINATOR: denom_r  <= cfg_wdata[apss_pkg::DENOM_W-1:0];
        default: ;
      endcase
    end
  end

  // datapath payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      unity_r  <= in_tdata[RW-1:0];
      high_r   <= in_tdata[2*RW-1:RW];
      offs_r   <= in_tdata[3*RW-1:2*RW];
      supply_r <= in_tdata[4*RW-1:3*RW];
    end
    if (state_r == apss_pkg::ST_PREP) begin
      neg_r  <= value < offset;
      prod_r <= apss_pkg::PROD_W'(diff) * apss_pkg::PROD_W'(numer_r);
      den_r  <= den_sel;
    end
    if (state_r == apss_pkg::ST_POW_WAIT && div_res.done)
      pow_r <= neg_r ? '0 : div_res.quot;
    if (state_r == apss_pkg::ST_BAT_WAIT && div_res.done)
      bat_r <= div_res.quot;
    if (emit)
      out_tdata_r <= {seq_r, bat_r, prev[3], prev[2], prev[1], pow_r};
  end

  // older values come from the history before this item shifts in
  for (genvar k = 1; k < 4; k++) begin : g_prev
    if (k < HISTORY_DEPTH) begin : g_tap
      assign prev[k] = hist_r[k-1];
    end else begin : g_zero
      assign prev[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) hist_r[i] <= '0;
      seq_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (emit) begin
        for (int i = HISTORY_DEPTH - 1; i > 0; i--) hist_r[i] <= hist_r[i-1];
        hist_r[0]    <= pow_r;
        seq_r        <= seq_r + 1'b1;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign out_tdata  = out_tdata_r;
  assign out_tvalid = out_tvalid_r;

  a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> seq_r == $past(seq_r) + 1'b1) else $error("sequence count skipped");
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == apss_pkg::ST_POW_WAIT || state_r == apss_pkg::ST_BAT_WAIT))
    else $error("divider result with nobody waiting");
  a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == apss_pkg::ST_PREP) else $error("accepted item not started");
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_tvalid_r) else $error("result emitted without valid");

endmodule
